FILE: src/ipdd_pkg.sv
// Shared types and constants for the payload deframer.
`default_nettype none
package ipdd_pkg;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LINK    = 3'd1,
        PH_SEP     = 3'd2,
        PH_DIGITS  = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] HEADER_LEN = 3'd5;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        last;
        logic [15:0] declared_length;
    } beat_t;

    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0: c = CH_PLUS;
            3'd1: c = CH_I;
            3'd2: c = CH_P;
            3'd3: c = CH_D;
            3'd4: c = CH_COMMA;
            default: c = CH_PLUS;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: src/ipdd_parser.sv
// Byte-wise header parser and payload counter of the deframer.
`default_nettype none
module ipdd_parser
    import ipdd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        beat_en,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [15:0] max_emit,
    output beat_t            res_beat,
    output logic             res_valid
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  match_pos_reg, match_pos_next;
    logic [15:0] length_accum_reg, length_accum_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] bytes_emitted_reg, bytes_emitted_next;

    logic [2:0]  hunt_pos;
    logic [2:0]  hunt_pos_next;
    logic        hunt_done;
    logic [19:0] accum_val;
    logic        is_digit;
    logic [15:0] left_dec;
    logic [15:0] emitted_inc;
    logic        emit_ok;

    always_comb begin
        hunt_pos = (match_pos_reg >= HEADER_LEN) ? 3'd0 : match_pos_reg;
        hunt_done = 1'b0;
        if (rx_byte == hdr_char(hunt_pos)) begin
            hunt_pos_next = hunt_pos + 3'd1;
            if (hunt_pos_next == HEADER_LEN) begin
                hunt_done = 1'b1;
                hunt_pos_next = 3'd0;
            end
        end else if (rx_byte == CH_PLUS) begin
            hunt_pos_next = 3'd1;
        end else begin
            hunt_pos_next = 3'd0;
        end
    end

    always_comb begin
        is_digit = rx_byte inside {[CH_ZERO:CH_NINE]};
        accum_val = ({4'd0, length_accum_reg} << 3) + ({4'd0, length_accum_reg} << 1)
                  + {16'd0, rx_byte[3:0]};
        left_dec = (bytes_left_reg != 16'd0) ? bytes_left_reg - 16'd1 : 16'd0;
        emitted_inc = bytes_emitted_reg + 16'd1;
        emit_ok = bytes_emitted_reg < max_emit;
    end

    always_comb begin
        phase_next = phase_reg;
        match_pos_next = match_pos_reg;
        length_accum_next = length_accum_reg;
        bytes_left_next = bytes_left_reg;
        bytes_emitted_next = bytes_emitted_reg;
        case (phase_reg)
            PH_LINK: begin
                phase_next = PH_SEP;
            end
            PH_SEP: begin
                phase_next = PH_DIGITS;
                length_accum_next = 16'd0;
            end
            PH_DIGITS: begin
                if (is_digit) begin
                    if (accum_val > 20'd65535) begin
                        phase_next = PH_HUNT;
                        match_pos_next = 3'd0;
                    end else begin
                        length_accum_next = accum_val[15:0];
                    end
                end else if (rx_byte == CH_COLON) begin
                    match_pos_next = 3'd0;
                    if (length_accum_reg == 16'd0) begin
                        phase_next = PH_HUNT;
                    end else begin
                        phase_next = PH_PAYLOAD;
                        bytes_left_next = length_accum_reg;
                        bytes_emitted_next = 16'd0;
                    end
                end else begin
                    // A stray byte drops the frame and is rescanned from a clean match.
                    match_pos_next = (rx_byte == CH_PLUS) ? 3'd1 : 3'd0;
                    phase_next = PH_HUNT;
                end
            end
            PH_PAYLOAD: begin
                bytes_left_next = left_dec;
                if (emit_ok) begin
                    bytes_emitted_next = emitted_inc;
                end
                if (left_dec == 16'd0) begin
                    phase_next = PH_HUNT;
                    match_pos_next = 3'd0;
                end
            end
            default: begin
                match_pos_next = hunt_pos_next;
                phase_next = hunt_done ? PH_LINK : PH_HUNT;
            end
        endcase
    end

    always_comb begin
        res_valid = beat_en && (phase_reg == PH_PAYLOAD) && emit_ok;
        res_beat.payload_byte = rx_byte;
        res_beat.last = (emitted_inc == max_emit) || (left_dec == 16'd0);
        res_beat.declared_length = length_accum_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            match_pos_reg <= 3'd0;
            length_accum_reg <= 16'd0;
            bytes_left_reg <= 16'd0;
            bytes_emitted_reg <= 16'd0;
        end else if (beat_en) begin
            phase_reg <= phase_next;
            match_pos_reg <= match_pos_next;
            length_accum_reg <= length_accum_next;
            bytes_left_reg <= bytes_left_next;
            bytes_emitted_reg <= bytes_emitted_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/ipdd_out_buf.sv
// Two-entry output register with skid stage for result beats.
`default_nettype none
module ipdd_out_buf
    import ipdd_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire beat_t push_beat,
    output logic       can_accept,
    output logic       out_valid,
    output beat_t      out_beat,
    input  wire logic  out_ready
);

    logic  main_valid_reg;
    beat_t main_beat_reg;
    logic  skid_valid_reg;
    beat_t skid_beat_reg;
    logic  pop;

    assign pop = main_valid_reg && out_ready;
    assign can_accept = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_beat = main_beat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            if (!main_valid_reg || pop) begin
                main_beat_reg <= push_beat;
            end else begin
                skid_beat_reg <= push_beat;
            end
        end else if (pop && skid_valid_reg) begin
            main_beat_reg <= skid_beat_reg;
        end
    end

endmodule
`default_nettype wire

FILE: src/at_ipd_payload_deframer_core.sv
// Top level of the payload deframer for received modem byte streams.
//
// Received bytes enter on the s_ channel, one byte per beat. The block hunts
// for the "+IPD," header, skips the link id and separator, reads the decimal
// length up to ':' and then forwards up to max_emit payload bytes of the
// frame on the m_ channel, marking the last forwarded byte with m_last.
// Every result beat also carries the declared frame length.
// A byte is accepted in every cycle in which s_ready is high, so the
// throughput is one byte per cycle. Each result is registered in the output
// stages before it appears on the m_ channel. The output holds one result
// register plus a one-beat skid stage, so a byte is still accepted while a
// result waits; s_ready falls only when both hold a result, and rises again
// once the receiver takes one. max_emit is written through cfg_we and
// cfg_wdata; the user must write it only while the block is idle, and the
// block itself does not enforce this. Synchronous reset clears the parser to
// header hunting, empties the output stages and sets max_emit to 65535.
`default_nettype none
module at_ipd_payload_deframer_core
    import ipdd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_payload_byte,
    output logic             m_last,
    output logic [15:0]      m_declared_length
);

    logic [15:0] max_emit_reg;
    logic        beat_en;
    logic        res_valid;
    beat_t       res_beat;
    beat_t       out_beat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_emit_reg <= 16'hFFFF;
        end else if (cfg_we) begin
            max_emit_reg <= cfg_wdata;
        end
    end

    assign beat_en = s_valid && s_ready;

    ipdd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat_en   (beat_en),
        .rx_byte   (s_rx_byte),
        .max_emit  (max_emit_reg),
        .res_beat  (res_beat),
        .res_valid (res_valid)
    );

    ipdd_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (res_valid),
        .push_beat  (res_beat),
        .can_accept (s_ready),
        .out_valid  (m_valid),
        .out_beat   (out_beat),
        .out_ready  (m_ready)
    );

    assign m_payload_byte = out_beat.payload_byte;
    assign m_last = out_beat.last;
    assign m_declared_length = out_beat.declared_length;

endmodule
`default_nettype wire

FILE: dv/tb_at_ipd_payload_deframer_core.sv
// Testbench for the +IPD payload deframer, checked beat by beat against a built-in predictor.
`timescale 1ns / 100ps
module tb_at_ipd_payload_deframer_core;
    import ipdd_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RANDOM_BYTES_PER_SETTING = 100;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_payload_byte;
    logic        m_last;
    logic [15:0] m_declared_length;

    at_ipd_payload_deframer_core DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_payload_byte    (m_payload_byte),
        .m_last            (m_last),
        .m_declared_length (m_declared_length)
    );

    localparam logic [7:0] HEADER_CHARS [5] = '{CH_PLUS, CH_I, CH_P, CH_D, CH_COMMA};

    phase_t      parse_phase = PH_HUNT;
    logic [2:0]  header_pos = 3'd0;
    logic [15:0] frame_length = 16'd0;
    logic [15:0] frame_remaining = 16'd0;
    logic [15:0] frame_forwarded = 16'd0;
    logic [15:0] emit_cap = 16'hFFFF;

    beat_t pending_beats[$];
    int    err_count = 0;
    int    beats_seen = 0;
    int    bytes_sent = 0;
    int    frames_sent = 0;
    int    cycle_count = 0;
    bit    no_idle = 1'b0;

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 19);
    end

    always @(posedge aclk) begin
        beat_t want;
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (pending_beats.size() == 0) begin
                $error("Unexpected beat: payload_byte %0h last %0b declared_length %0d",
                       m_payload_byte, m_last, m_declared_length);
                err_count++;
            end else begin
                want = pending_beats.pop_front();
                if (m_payload_byte !== want.payload_byte) begin
                    $error("payload_byte: expected %0h, actual %0h",
                           want.payload_byte, m_payload_byte);
                    err_count++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, m_last);
                    err_count++;
                end
                if (m_declared_length !== want.declared_length) begin
                    $error("declared_length: expected %0d, actual %0d",
                           want.declared_length, m_declared_length);
                    err_count++;
                end
            end
        end
    end

    task automatic match_header_char(input logic [7:0] b);
        logic [2:0] pos;
        pos = (header_pos >= HEADER_LEN) ? 3'd0 : header_pos;
        if (b == HEADER_CHARS[pos]) begin
            pos = pos + 3'd1;
            if (pos == HEADER_LEN) begin
                parse_phase = PH_LINK;
                pos = 3'd0;
            end
        end else if (b == CH_PLUS) begin
            pos = 3'd1;
        end else begin
            pos = 3'd0;
        end
        header_pos = pos;
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        int    grown;
        beat_t beat;
        case (parse_phase)
            PH_LINK: begin
                parse_phase = PH_SEP;
            end
            PH_SEP: begin
                parse_phase = PH_DIGITS;
                frame_length = 16'd0;
            end
            PH_DIGITS: begin
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    grown = int'(frame_length) * 10 + int'(b - CH_ZERO);
                    if (grown > 65535) begin
                        parse_phase = PH_HUNT;
                        header_pos = 3'd0;
                    end else begin
                        frame_length = grown[15:0];
                    end
                end else if (b == CH_COLON) begin
                    header_pos = 3'd0;
                    if (frame_length == 16'd0) begin
                        parse_phase = PH_HUNT;
                    end else begin
                        parse_phase = PH_PAYLOAD;
                        frame_remaining = frame_length;
                        frame_forwarded = 16'd0;
                    end
                end else begin
                    parse_phase = PH_HUNT;
                    header_pos = 3'd0;
                    match_header_char(b);
                end
            end
            PH_PAYLOAD: begin
                if (frame_remaining != 16'd0) begin
                    frame_remaining = frame_remaining - 16'd1;
                end
                if (frame_forwarded < emit_cap) begin
                    frame_forwarded = frame_forwarded + 16'd1;
                    beat.payload_byte = b;
                    beat.last = (frame_forwarded == emit_cap) || (frame_remaining == 16'd0);
                    beat.declared_length = frame_length;
                    pending_beats.push_back(beat);
                end
                if (frame_remaining == 16'd0) begin
                    parse_phase = PH_HUNT;
                    header_pos = 3'd0;
                end
            end
            default: begin
                parse_phase = PH_HUNT;
                match_header_char(b);
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        while (!no_idle && $urandom_range(0, 99) < 19) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        deframe_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    task automatic send_random_bytes(input int count);
        repeat (count) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_header(input logic [7:0] link_id, input logic [7:0] separator);
        send_text("+IPD,");
        send_byte(link_id);
        send_byte(separator);
    endtask

    task automatic send_frame(input int len, input int zero_pad);
        string digits;
        digits = "";
        repeat (zero_pad) digits = {digits, "0"};
        send_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        send_text({digits, $sformatf("%0d:", len)});
        send_random_bytes(len);
        frames_sent++;
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_max_emit(input logic [15:0] value);
        settle();
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        emit_cap = value;
    endtask

    task automatic test_basic_frames();
        send_text("xx+IPD,0,5:");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("abc");
        send_text("+IPD,1,0:");
        send_text("+IPD,1,:");
        send_header(8'hFF, 8'h00);
        send_text("2:");
        send_byte(8'hFF);
        send_byte(8'h00);
        frames_sent += 4;
    endtask

    task automatic test_header_restart();
        send_text("++IPD,0,2:ab");
        send_text("+IP+IPD,0,1:z");
        send_text("+IPD+IPD,3,1:q");
        frames_sent += 3;
    endtask

    task automatic test_bad_length();
        send_text("+IPD,0,65536:xy");
        send_text("+IPD,0,1x+IPD,0,1:k");
        send_text("+IPD,0,3+IPD,0,2:mn");
        frames_sent += 3;
    endtask

    task automatic test_emit_limit();
        set_max_emit(16'd0);
        send_text("+IPD,0,4:abcd");
        set_max_emit(16'd1);
        send_text("+IPD,0,3:efg");
        set_max_emit(16'd3);
        send_text("+IPD,0,3:hij");
        set_max_emit(16'hFFFF);
        send_text("+IPD,0,6:klm");
        set_max_emit(16'd2);
        send_text("nop");
        set_max_emit(16'd5);
        send_text("+IPD,0,8:qr");
        set_max_emit(16'd3);
        send_text("stuvwx");
        frames_sent += 5;
    endtask

    task automatic test_back_to_back();
        set_max_emit(16'hFFFF);
        no_idle = 1'b1;
        repeat (20) send_frame($urandom_range(0, 10), 0);
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        logic [15:0] settings [6];
        int          start_count;
        int          ignored;
        int          pick;
        settings = '{16'hFFFF, 16'd0, 16'd1, 16'($urandom_range(2, 9)),
                     16'($urandom_range(0, 65535)), 16'hFFFF};
        foreach (settings[k]) begin
            set_max_emit(settings[k]);
            start_count = bytes_sent;
            ignored = 0;
            while (bytes_sent - start_count - ignored < RANDOM_BYTES_PER_SETTING) begin
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 80) begin
                        send_frame($urandom_range(0, 12), 0);
                    end else if (pick < 95) begin
                        send_frame($urandom_range(13, 64), 0);
                    end else begin
                        send_frame($urandom_range(65, 300), 0);
                    end
                end else if (pick < 75) begin
                    send_frame($urandom_range(0, 6), $urandom_range(1, 3));
                end else if (pick < 85) begin
                    repeat ($urandom_range(1, 6)) begin
                        send_byte(($urandom_range(0, 99) < 30) ? CH_PLUS
                                                              : 8'($urandom_range(0, 255)));
                        ignored++;
                    end
                end else if (pick < 91) begin
                    send_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    send_text($sformatf("%0d", $urandom_range(65536, 999999)));
                    send_random_bytes($urandom_range(0, 3));
                end else if (pick < 97) begin
                    send_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    send_text($sformatf("%0d", $urandom_range(0, 99)));
                    pick = $urandom_range(0, 255);
                    while ((pick >= CH_ZERO && pick <= CH_NINE) || pick == CH_COLON) begin
                        pick = $urandom_range(0, 255);
                    end
                    send_byte(($urandom_range(0, 1) == 0) ? CH_PLUS : 8'(pick));
                end else begin
                    send_text("+IP");
                    send_byte(8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    task automatic test_longest_frame();
        set_max_emit(16'd3);
        no_idle = 1'b1;
        send_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        send_text("65535:");
        send_random_bytes(8);
        frames_sent++;
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_basic_frames();
        test_header_restart();
        test_bad_length();
        test_emit_limit();
        test_back_to_back();
        test_random_traffic();
        test_longest_frame();
        settle();
        repeat (10) @(posedge aclk);
        $display("Sent %0d bytes in about %0d frames, checked %0d payload beats.",
                 bytes_sent, frames_sent, beats_seen);
        $display("Covered header restarts, bad and oversized lengths, and emit caps 0 to 65535.");
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
